// ===== hw/rtl/lvf_pkg.sv =====
// Shared constants and register indexes for the letterbox viewport fit block.
package lvf_pkg;

  localparam int REF_BITS     = 14;
  localparam int CFG_IDX_BITS = 2;
  localparam int OUT_FIELDS   = 10;

  localparam logic [CFG_IDX_BITS-1:0] REG_REF_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_REF_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAPPED     = 2'd2;

  localparam logic [REF_BITS-1:0] REF_WIDTH_RESET  = 14'd1920;
  localparam logic [REF_BITS-1:0] REF_HEIGHT_RESET = 14'd1080;

endpackage

// ===== hw/rtl/lvf_div_cell.sv =====
// One restoring-division cell: retires one quotient bit per beat position.
module lvf_div_cell #(
  parameter int NW = 16,
  parameter int DW = 16,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DW+NW-1:0]     acc_in,
  input  logic [DW-1:0]        div_in,
  input  logic [SW-1:0]        side_in,
  output logic [DW+NW-1:0]     acc_out,
  output logic [DW-1:0]        div_out,
  output logic [SW-1:0]        side_out
);

  logic [DW+NW:0] shifted;
  logic [DW:0]    top;
  logic           fits;
  logic [DW:0]    top_sub;
  logic [DW+NW-1:0] acc_next;

  // The remainder sits in the high bits; the low bits fill with quotient bits.
  always_comb begin
    shifted  = {acc_in, 1'b0};
    top      = shifted[DW+NW:NW];
    fits     = top >= {1'b0, div_in};
    top_sub  = top - {1'b0, div_in};
    acc_next = fits ? {top_sub[DW-1:0], shifted[NW-1:1], 1'b1}
                    : {top[DW-1:0], shifted[NW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_out  <= acc_next;
      div_out  <= div_in;
      side_out <= side_in;
    end
  end

endmodule

// ===== hw/rtl/lvf_div_chain.sv =====
// A row of NW division cells giving an NW-bit quotient.
module lvf_div_chain #(
  parameter int NW = 16,
  parameter int DW = 16,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DW+NW-1:0]     acc_in,
  input  logic [DW-1:0]        div_in,
  input  logic [SW-1:0]        side_in,
  output logic [DW+NW-1:0]     acc_out,
  output logic [SW-1:0]        side_out
);

  logic [DW+NW-1:0] acc  [0:NW];
  logic [DW-1:0]    dv   [0:NW];
  logic [SW-1:0]    side [0:NW];

  assign acc[0]  = acc_in;
  assign dv[0]   = div_in;
  assign side[0] = side_in;

  for (genvar i = 0; i < NW; i++) begin : g_cell
    lvf_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
      .clk      (clk),
      .en       (en),
      .acc_in   (acc[i]),
      .div_in   (dv[i]),
      .side_in  (side[i]),
      .acc_out  (acc[i+1]),
      .div_out  (dv[i+1]),
      .side_out (side[i+1])
    );
  end

  assign acc_out  = acc[NW];
  assign side_out = side[NW];

endmodule

// ===== hw/rtl/letterbox_viewport_fit.sv =====
// Top level: letterbox viewport fit over two rows of pipelined division cells.
//
//  channel | direction | handshake        | payload
//  s_      | in        | tvalid / tready  | tdata: 4 surface dims
//  m_      | out       | tvalid / tready  | tdata: 10 result dims, tuser: status
//  cfg_    | in        | cfg_we           | cfg_index, cfg_data
//
// One beat is accepted per cycle unless m_ stalls; its path is stage 0, the aspect
// row (DIM_BITS+14 cells), B, C, the projection row (DIM_BITS cells), the output.
// rst clears the valid pipeline, m_tvalid and capped, and reloads ref_w/ref_h defaults.
// A stall on m_ freezes the whole pipeline and drops s_tready in the same cycle.
module letterbox_viewport_fit #(
  parameter int DIM_BITS = 16,
  parameter int REF_MAX  = 10000
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // log_w, log_h, fb_w, fb_h
  input  logic [((4*DIM_BITS+7)/8)*8-1:0]        s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // view_x, view_y, view_w, view_h, crop_x, crop_y, crop_w, crop_h, world_w, world_h
  output logic [((lvf_pkg::OUT_FIELDS*DIM_BITS+7)/8)*8-1:0] m_tdata,
  // status
  output logic                                   m_tuser,
  input  logic                                   cfg_we,
  input  logic [lvf_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [lvf_pkg::REF_BITS-1:0]           cfg_data
);
  import lvf_pkg::*;

  localparam int D     = DIM_BITS;
  localparam int NA    = D + REF_BITS;
  localparam int LAT   = 1 + NA + 2 + D;
  localparam int OUT_W = ((OUT_FIELDS*DIM_BITS+7)/8)*8;
  localparam int CW    = D + REF_BITS;

  logic [REF_BITS-1:0] ref_w, ref_h;
  logic                capped;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_w  <= REF_WIDTH_RESET;
      ref_h  <= REF_HEIGHT_RESET;
      capped <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REF_WIDTH:  ref_w  <= cfg_data;
        REG_REF_HEIGHT: ref_h  <= cfg_data;
        REG_CAPPED:     capped <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic [LAT-1:0] vld;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // Stage 0: clamp dims, form the two aspect products.
  logic [D-1:0] in_lw, in_lh, in_fw, in_fh;
  logic [D-1:0] p_lw, p_lh, p_fw, p_fh;
  logic [NA-1:0] p_num_h, p_num_w;
  logic          p_bad;
  logic          ref_bad;

  always_comb begin
    in_lw = s_tdata[D-1:0];
    in_lh = s_tdata[2*D-1:D];
    in_fw = s_tdata[3*D-1:2*D];
    in_fh = s_tdata[4*D-1:3*D];
    if (in_lw == '0) in_lw = D'(1);
    if (in_lh == '0) in_lh = D'(1);
    if (in_fw == '0) in_fw = D'(1);
    if (in_fh == '0) in_fh = D'(1);
    ref_bad = (ref_w == '0) || (ref_w > REF_BITS'(REF_MAX)) ||
              (ref_h == '0) || (ref_h > REF_BITS'(REF_MAX));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_lw    <= in_lw;
      p_lh    <= in_lh;
      p_fw    <= in_fw;
      p_fh    <= in_fh;
      p_num_h <= NA'(in_lw) * NA'(ref_h);
      p_num_w <= NA'(in_lh) * NA'(ref_w);
      p_bad   <= ref_bad;
    end
  end

  // Aspect row: height-for-width and width-for-height quotients.
  logic [REF_BITS+NA-1:0] a_acc_h, a_acc_w;
  logic [2*D-1:0]         a_side_h;
  logic [2*D:0]           a_side_w;

  lvf_div_chain #(.NW(NA), .DW(REF_BITS), .SW(2*D)) u_div_h (
    .clk      (clk),
    .en       (adv),
    .acc_in   ({{REF_BITS{1'b0}}, p_num_h}),
    .div_in   (ref_w),
    .side_in  ({p_lh, p_lw}),
    .acc_out  (a_acc_h),
    .side_out (a_side_h)
  );

  lvf_div_chain #(.NW(NA), .DW(REF_BITS), .SW(2*D+1)) u_div_w (
    .clk      (clk),
    .en       (adv),
    .acc_in   ({{REF_BITS{1'b0}}, p_num_w}),
    .div_in   (ref_h),
    .side_in  ({p_bad, p_fh, p_fw}),
    .acc_out  (a_acc_w),
    .side_out (a_side_w)
  );

  // Stage B: choose the fit and center it.
  logic [D-1:0] a_lw, a_lh, a_fw, a_fh;
  logic         a_bad;
  logic [NA-1:0] q_h, q_w;
  logic [D-1:0] fit_w, fit_h;
  logic [D-1:0] b_vx, b_vy, b_vw, b_vh, b_lw, b_lh, b_fw, b_fh;
  logic         b_bad;

  always_comb begin
    a_lw  = a_side_h[D-1:0];
    a_lh  = a_side_h[2*D-1:D];
    a_fw  = a_side_w[D-1:0];
    a_fh  = a_side_w[2*D-1:D];
    a_bad = a_side_w[2*D];
    q_h   = a_acc_h[NA-1:0];
    q_w   = a_acc_w[NA-1:0];
    if (q_h > NA'(a_lh)) begin
      fit_w = q_w[D-1:0];
      fit_h = a_lh;
    end else begin
      fit_w = a_lw;
      fit_h = q_h[D-1:0];
    end
    if (fit_w == '0) fit_w = D'(1);
    if (fit_h == '0) fit_h = D'(1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_vw  <= fit_w;
      b_vh  <= fit_h;
      b_vx  <= (a_lw - fit_w) >> 1;
      b_vy  <= (a_lh - fit_h) >> 1;
      b_lw  <= a_lw;
      b_lh  <= a_lh;
      b_fw  <= a_fw;
      b_fh  <= a_fh;
      b_bad <= a_bad;
    end
  end

  // Stage C: edge numerators for the round-half projection.
  logic [D-1:0]   c_lw, c_lh, c_vx, c_vy, c_vw, c_vh;
  logic [2*D-1:0] c_n_l, c_n_r, c_n_t, c_n_b;
  logic           c_bad;
  logic [D-1:0]   e_right, e_bottom;

  assign e_right  = b_vx + b_vw;
  assign e_bottom = b_vy + b_vh;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_n_l <= (2*D)'(b_vx) * (2*D)'(b_fw) + (2*D)'(b_lw >> 1);
      c_n_r <= (2*D)'(e_right) * (2*D)'(b_fw) + (2*D)'(b_lw >> 1);
      c_n_t <= (2*D)'(b_vy) * (2*D)'(b_fh) + (2*D)'(b_lh >> 1);
      c_n_b <= (2*D)'(e_bottom) * (2*D)'(b_fh) + (2*D)'(b_lh >> 1);
      c_lw  <= b_lw;
      c_lh  <= b_lh;
      c_vx  <= b_vx;
      c_vy  <= b_vy;
      c_vw  <= b_vw;
      c_vh  <= b_vh;
      c_bad <= b_bad;
    end
  end

  // Projection row: the high half of each numerator is below the divisor,
  // so it seeds the remainder and only D quotient bits are left.
  logic [2*D-1:0] d_acc_l, d_acc_r, d_acc_t, d_acc_b;
  logic [D-1:0]   d_vx, d_vy, d_vw;
  logic [D:0]     d_side_b;

  lvf_div_chain #(.NW(D), .DW(D), .SW(D)) u_div_l (
    .clk (clk), .en (adv), .acc_in (c_n_l), .div_in (c_lw),
    .side_in (c_vx), .acc_out (d_acc_l), .side_out (d_vx)
  );

  lvf_div_chain #(.NW(D), .DW(D), .SW(D)) u_div_r (
    .clk (clk), .en (adv), .acc_in (c_n_r), .div_in (c_lw),
    .side_in (c_vy), .acc_out (d_acc_r), .side_out (d_vy)
  );

  lvf_div_chain #(.NW(D), .DW(D), .SW(D)) u_div_t (
    .clk (clk), .en (adv), .acc_in (c_n_t), .div_in (c_lh),
    .side_in (c_vw), .acc_out (d_acc_t), .side_out (d_vw)
  );

  lvf_div_chain #(.NW(D), .DW(D), .SW(D+1)) u_div_b (
    .clk (clk), .en (adv), .acc_in (c_n_b), .div_in (c_lh),
    .side_in ({c_bad, c_vh}), .acc_out (d_acc_b), .side_out (d_side_b)
  );

  // Output stage: crop extents, world raster, and the result beat.
  logic [D-1:0] crop_l, crop_t, crop_w, crop_h, world_w, world_h;
  logic [D-1:0] d_vh;
  logic         d_bad;
  logic [OUT_W-1:0] data_next;

  always_comb begin
    d_vh   = d_side_b[D-1:0];
    d_bad  = d_side_b[D];
    crop_l = d_acc_l[D-1:0];
    crop_t = d_acc_t[D-1:0];
    crop_w = d_acc_r[D-1:0] - crop_l;
    crop_h = d_acc_b[D-1:0] - crop_t;
    world_w = crop_w;
    world_h = crop_h;
    // Compare at a width that holds both the crop and the reference size.
    if (capped && ((CW'(crop_w) > CW'(ref_w)) || (CW'(crop_h) > CW'(ref_h)))) begin
      world_w = D'(ref_w);
      world_h = D'(ref_h);
    end
    data_next = OUT_W'({world_h, world_w, crop_h, crop_w, crop_t, crop_l,
                        d_vh, d_vw, d_vy, d_vx});
    if (d_bad) data_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= data_next;
      m_tuser <= d_bad;
    end
  end

endmodule

// ===== tb/tb_letterbox_viewport_fit.sv =====
// Self-checking testbench for the letterbox viewport fit block.
`timescale 1ns / 1ps

module tb_letterbox_viewport_fit;
  import lvf_pkg::*;

  localparam int DIM_BITS = 16;
  localparam int REF_MAX  = 10000;
  localparam int LATENCY  = 2 * DIM_BITS + 18;

  typedef struct packed {
    logic [15:0] fb_h;
    logic [15:0] fb_w;
    logic [15:0] log_h;
    logic [15:0] log_w;
  } surface_t;

  typedef struct packed {
    logic        status;
    logic [15:0] world_h;
    logic [15:0] world_w;
    logic [15:0] crop_h;
    logic [15:0] crop_w;
    logic [15:0] crop_y;
    logic [15:0] crop_x;
    logic [15:0] view_h;
    logic [15:0] view_w;
    logic [15:0] view_y;
    logic [15:0] view_x;
  } fit_t;

  typedef struct {
    surface_t s;
    logic     has_fixed;
    fit_t     fixed;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [159:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [REF_BITS-1:0] cfg_data = '0;

  logic [REF_BITS-1:0] ref_w = REF_WIDTH_RESET;
  logic [REF_BITS-1:0] ref_h = REF_HEIGHT_RESET;
  logic capped = 1'b0;

  fit_t pending_fits[$];
  int errors = 0;
  bit sending_done = 1'b0;

  letterbox_viewport_fit #(.DIM_BITS(DIM_BITS), .REF_MAX(REF_MAX)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] round_edge(logic [63:0] e, logic [63:0] l, logic [63:0] f);
    return (e * f + l / 2) / l;
  endfunction

  function automatic fit_t fit_surface(surface_t s);
    logic [63:0] lw, lh, fw, fh, vw, vh, vx, vy, lft, rgt, top, bot, cw, ch, ww, wh;
    fit_t r;
    r = '0;
    if (ref_w < 1 || ref_w > REF_MAX || ref_h < 1 || ref_h > REF_MAX) begin
      r.status = 1'b1;
      return r;
    end
    lw = (s.log_w == 0) ? 1 : s.log_w;
    lh = (s.log_h == 0) ? 1 : s.log_h;
    fw = (s.fb_w == 0) ? 1 : s.fb_w;
    fh = (s.fb_h == 0) ? 1 : s.fb_h;
    vw = lw;
    vh = (lw * ref_h) / ref_w;
    if (vh > lh) begin
      vh = lh;
      vw = (lh * ref_w) / ref_h;
    end
    if (vw == 0) vw = 1;
    if (vh == 0) vh = 1;
    vx = (lw - vw) / 2;
    vy = (lh - vh) / 2;
    lft = round_edge(vx, lw, fw);
    rgt = round_edge(vx + vw, lw, fw);
    top = round_edge(vy, lh, fh);
    bot = round_edge(vy + vh, lh, fh);
    cw = rgt - lft;
    ch = bot - top;
    ww = cw;
    wh = ch;
    if (capped && !(cw <= ref_w && ch <= ref_h)) begin
      ww = ref_w;
      wh = ref_h;
    end
    r.view_x = vx[15:0];
    r.view_y = vy[15:0];
    r.view_w = vw[15:0];
    r.view_h = vh[15:0];
    r.crop_x = lft[15:0];
    r.crop_y = top[15:0];
    r.crop_w = cw[15:0];
    r.crop_h = ch[15:0];
    r.world_w = ww[15:0];
    r.world_h = wh[15:0];
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [REF_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_REF_WIDTH:  ref_w = val;
      REG_REF_HEIGHT: ref_h = val;
      REG_CAPPED:     capped = val[0];
      default: ;
    endcase
  endtask

  // The last beat of a burst leaves s_tvalid high; it drops here.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_fits.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // Drives one surface beat; fixed is compared with the prediction when given.
  task automatic send_surface(surface_t s, logic has_fixed, fit_t fixed);
    fit_t p;
    int idle;
    idle = $urandom_range(0, 13);
    if (idle != 0) begin
      s_tvalid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    p = fit_surface(s);
    if (has_fixed && p !== fixed) begin
      errors++;
      if (errors <= 10)
        $display("table row %h: expected %h, predicted %h", s, fixed, p);
    end
    s_tvalid <= 1'b1;
    s_tdata <= s;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_fits.push_back(p);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_dim();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 3));
      1: return 16'hFFFF - 16'($urandom_range(0, 3));
      2: return 16'($urandom_range(1, 4096));
      default: return 16'($urandom);
    endcase
  endfunction

  // Output side: random stall per beat, then compare against the oldest prediction.
  initial begin
    fit_t got, want;
    int wait_cycles;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      wait_cycles = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) wait_cycles = 0;
      if (wait_cycles != 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got = {m_tuser, m_tdata};
      if (pending_fits.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = pending_fits.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("result mismatch: expected %h, got %h", want, got);
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    surface_t s;
    fit_t zero_fit;
    int settings[6][3];
    zero_fit = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes of the surface fields under reset settings.
    r.has_fixed = 1'b0;
    r.fixed = zero_fit;
    r.s = '{16'd1080, 16'd1920, 16'd1080, 16'd1920}; rows.push_back(r);
    r.s = '0; rows.push_back(r);
    r.s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}; rows.push_back(r);
    r.s = '{16'd1, 16'hFFFF, 16'd1, 16'hFFFF}; rows.push_back(r);
    r.s = '{16'hFFFF, 16'd1, 16'hFFFF, 16'd1}; rows.push_back(r);
    r.s = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0}; rows.push_back(r);
    r.s = '{16'd1440, 16'd2560, 16'd720, 16'd1280}; rows.push_back(r);
    r.s = '{16'd768, 16'd1024, 16'd768, 16'd1024}; rows.push_back(r);
    r.s = '{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555}; rows.push_back(r);
    foreach (rows[i]) send_surface(rows[i].s, rows[i].has_fixed, rows[i].fixed);
    drain();

    // Invalid reference sizes give status only.
    rows.delete();
    r.has_fixed = 1'b1;
    r.fixed = zero_fit;
    r.fixed.status = 1'b1;
    r.s = '{16'd600, 16'd800, 16'd600, 16'd800}; rows.push_back(r);
    r.s = '1; rows.push_back(r);
    write_reg(REG_REF_WIDTH, 14'd0);
    foreach (rows[i]) send_surface(rows[i].s, 1'b1, rows[i].fixed);
    drain();
    write_reg(REG_REF_WIDTH, 14'd10001);
    foreach (rows[i]) send_surface(rows[i].s, 1'b1, rows[i].fixed);
    drain();
    write_reg(REG_REF_WIDTH, 14'd16);
    write_reg(REG_REF_HEIGHT, 14'h3FFF);
    foreach (rows[i]) send_surface(rows[i].s, 1'b1, rows[i].fixed);
    drain();
    // Out-of-range index must be ignored; write_reg leaves the model untouched.
    write_reg(2'd3, 14'h3FFF);
    // A tall reference on a narrow surface drives a fitted dimension to zero.
    write_reg(REG_REF_HEIGHT, 14'd10000);
    write_reg(REG_REF_WIDTH, 14'd1);
    write_reg(REG_CAPPED, 14'd1);
    s = '{16'd100, 16'd100, 16'd3, 16'd50000}; send_surface(s, 1'b0, zero_fit);
    s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1}; send_surface(s, 1'b0, zero_fit);
    drain();
    write_reg(REG_REF_WIDTH, 14'd10000);
    write_reg(REG_REF_HEIGHT, 14'd1);
    s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd7}; send_surface(s, 1'b0, zero_fit);
    s = '{16'd4000, 16'd4000, 16'd2, 16'd2}; send_surface(s, 1'b0, zero_fit);
    drain();

    // Random phases over a spread of reference settings.
    settings = '{'{1920, 1080, 0}, '{4, 3, 1}, '{1, 1, 1},
                 '{10000, 10000, 0}, '{16383, 16383, 1}, '{0, 0, 0}};
    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 6) begin
        write_reg(REG_REF_WIDTH, 14'(settings[ph][0]));
        write_reg(REG_REF_HEIGHT, 14'(settings[ph][1]));
        write_reg(REG_CAPPED, 14'(settings[ph][2]));
      end else begin
        write_reg(REG_REF_WIDTH, 14'($urandom_range(1, 4000)));
        write_reg(REG_REF_HEIGHT, 14'($urandom_range(1, 4000)));
        write_reg(REG_CAPPED, 14'($urandom_range(0, 1)));
      end
      for (int n = 0; n < 200; n++) begin
        s.log_w = rand_dim();
        s.log_h = rand_dim();
        s.fb_w = rand_dim();
        s.fb_h = rand_dim();
        send_surface(s, 1'b0, zero_fit);
      end
      drain();
    end
    sending_done = 1'b1;
  end

  initial begin
    wait (sending_done);
    if (errors == 0 && pending_fits.size() == 0) begin
      $display("tb_letterbox_viewport_fit: PASS");
    end else begin
      $display("tb_letterbox_viewport_fit: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_letterbox_viewport_fit: FAIL");
    $finish;
  end

endmodule

// ===== letterbox_viewport_fit.f =====
hw/rtl/lvf_pkg.sv
hw/rtl/lvf_div_cell.sv
hw/rtl/lvf_div_chain.sv
hw/rtl/letterbox_viewport_fit.sv
tb/tb_letterbox_viewport_fit.sv
